FILE: rtl/phc_pkg.sv
package phc_pkg;

    localparam int MAX_HITS_DEF  = 64;
    localparam int FRAC_BITS_DEF = 4;
    localparam logic [2:0]  RADIUS_RESET = 3'd2;
    localparam logic [17:0] CHARGE_SAT   = 18'h3FFFF;
    localparam logic [6:0]  SIZE_SAT     = 7'd127;
    localparam logic [11:0] CROW_SAT     = 12'hFFF;
    localparam logic [12:0] CCOL_SAT     = 13'h1FFF;

    typedef struct packed {
        logic        hit_valid;
        logic [7:0]  hit_row;
        logic [8:0]  hit_col;
        logic [11:0] hit_charge;
        logic        event_end;
    } hit_in_t;

    typedef struct packed {
        logic [17:0] cluster_charge;
        logic [6:0]  cluster_size;
        logic [11:0] centroid_row;
        logic [12:0] centroid_col;
        logic [7:0]  seed_row;
        logic [8:0]  seed_col;
        logic        zero_charge;
        logic        hits_dropped;
        logic        last_cluster;
    } cluster_out_t;

    typedef struct packed {
        logic [7:0]  row;
        logic [8:0]  col;
        logic [11:0] charge;
    } hit_entry_t;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_CLEAR,
        ST_SEED_RD,
        ST_SEED_EV,
        ST_HEAD_RD,
        ST_CUR_RD,
        ST_CUR_EV,
        ST_SCAN,
        ST_DIV,
        ST_OUT
    } state_t;

endpackage

FILE: rtl/pixel_hit_clusterer_unit.sv
// After the event-end word, the marks of all buffered hits are cleared.
// Each cluster then takes seed probes (mark read, mark check), one pass per member (list read,
// hit read, scan of all buffered hits), a close, a division of row and column in parallel
// (one bit per cycle; ending at once on zero charge) and an output wait for m_ready.
// Loading takes one hit word per cycle; no hit words are accepted while an event is clustered.
// Reset: aresetn synchronous active low; clears control state, radius returns to 2.
module pixel_hit_clusterer_unit #(
    parameter int MAX_HITS  = phc_pkg::MAX_HITS_DEF,
    parameter int FRAC_BITS = phc_pkg::FRAC_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  phc_pkg::hit_in_t      s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output phc_pkg::cluster_out_t m_data,
    input  logic                  cfg_we,
    input  logic [2:0]            cfg_wdata
);

    localparam int IW  = $clog2(MAX_HITS);
    localparam int CW  = $clog2(MAX_HITS + 1);
    localparam int SW  = 12 + CW;
    localparam int WRW = SW + 8;
    localparam int WCW = SW + 9;
    localparam int DW  = WCW + FRAC_BITS;
    localparam int DCW = $clog2(DW + 1);

    // memories
    phc_pkg::hit_entry_t hit_mem [MAX_HITS];
    logic                mark_mem [MAX_HITS];
    logic [IW-1:0]       list_mem [MAX_HITS];

    phc_pkg::hit_entry_t hit_rd_reg;
    logic                mark_rd_reg;
    logic [IW-1:0]       list_rd_reg;

    logic [IW-1:0]       hit_raddr, mark_raddr, mark_waddr, list_waddr;
    logic                hit_we, mark_we, mark_wdata, list_we;
    logic [IW-1:0]       list_wdata;
    phc_pkg::hit_entry_t hit_wdata;

    phc_pkg::state_t state_reg, state_next;
    logic [2:0]      radius_reg;
    logic [CW-1:0]   count_reg, count_next;
    logic            ovf_reg, ovf_next;
    logic [CW-1:0]   idx_reg, idx_next;      // clear / seed index
    logic [CW-1:0]   scan_reg, scan_next;
    logic [CW-1:0]   len_reg, len_next;
    logic [CW-1:0]   head_reg, head_next;
    logic [CW-1:0]   asg_reg, asg_next;
    logic [7:0]      cur_row_reg, cur_row_next;
    logic [8:0]      cur_col_reg, cur_col_next;
    logic [7:0]      seed_row_reg, seed_row_next;
    logic [8:0]      seed_col_reg, seed_col_next;
    logic [SW-1:0]   q_reg, q_next;
    logic [WRW-1:0]  wr_reg, wr_next;
    logic [WCW-1:0]  wc_reg, wc_next;
    logic [DCW-1:0]  dcnt_reg, dcnt_next;
    logic [DW-1:0]   dvr_reg, dvr_next, dvc_reg, dvc_next;
    logic [SW-1:0]   rmr_reg, rmr_next, rmc_reg, rmc_next;
    logic [DW-1:0]   qor_reg, qor_next, qoc_reg, qoc_next;
    logic            m_valid_reg, m_valid_next;
    phc_pkg::cluster_out_t m_data_reg, m_data_next;

    logic            accumulate;
    logic [19:0]     prod_r;
    logic [20:0]     prod_c;
    logic [8:0]      drow, dcol;
    logic            near;
    logic [SW:0]     shr, shc;
    logic            ger, gec;

    assign s_ready = (state_reg == phc_pkg::ST_LOAD);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // neighbor test and products on the freshly read hit
    always_comb begin
        drow = (hit_rd_reg.row > cur_row_reg) ? 9'(hit_rd_reg.row - cur_row_reg)
                                              : 9'(cur_row_reg - hit_rd_reg.row);
        dcol = (hit_rd_reg.col > cur_col_reg) ? (hit_rd_reg.col - cur_col_reg)
                                              : (cur_col_reg - hit_rd_reg.col);
        near = (drow <= 9'(radius_reg)) && (dcol <= 9'(radius_reg));
        prod_r = 20'(hit_rd_reg.row) * 20'(hit_rd_reg.charge);
        prod_c = 21'(hit_rd_reg.col) * 21'(hit_rd_reg.charge);
        shr = {rmr_reg, dvr_reg[DW-1]};
        shc = {rmc_reg, dvc_reg[DW-1]};
        ger = (shr >= {1'b0, q_reg});
        gec = (shc >= {1'b0, q_reg});
    end

    // sequencer
    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        ovf_next      = ovf_reg;
        idx_next      = idx_reg;
        scan_next     = scan_reg;
        len_next      = len_reg;
        head_next     = head_reg;
        asg_next      = asg_reg;
        cur_row_next  = cur_row_reg;
        cur_col_next  = cur_col_reg;
        seed_row_next = seed_row_reg;
        seed_col_next = seed_col_reg;
        q_next        = q_reg;
        wr_next       = wr_reg;
        wc_next       = wc_reg;
        dcnt_next     = dcnt_reg;
        dvr_next      = dvr_reg;
        dvc_next      = dvc_reg;
        rmr_next      = rmr_reg;
        rmc_next      = rmc_reg;
        qor_next      = qor_reg;
        qoc_next      = qoc_reg;
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;
        hit_we        = 1'b0;
        hit_wdata     = '{row: s_data.hit_row, col: s_data.hit_col,
                          charge: s_data.hit_charge};
        hit_raddr     = idx_reg[IW-1:0];
        mark_raddr    = idx_reg[IW-1:0];
        mark_we       = 1'b0;
        mark_waddr    = idx_reg[IW-1:0];
        mark_wdata    = 1'b0;
        list_we       = 1'b0;
        list_waddr    = len_reg[IW-1:0];
        list_wdata    = idx_reg[IW-1:0];
        accumulate    = 1'b0;

        unique case (state_reg)
            phc_pkg::ST_LOAD: begin
                if (s_valid) begin
                    if (s_data.hit_valid && count_reg < CW'(MAX_HITS)) begin
                        hit_we     = 1'b1;
                        count_next = count_reg + 1'b1;
                    end else if (s_data.hit_valid) begin
                        ovf_next = 1'b1;
                    end
                    if (s_data.event_end) begin
                        idx_next = '0;
                        asg_next = '0;
                        if (count_next == '0) begin
                            ovf_next = 1'b0;
                        end else begin
                            state_next = phc_pkg::ST_CLEAR;
                        end
                    end
                end
            end
            phc_pkg::ST_CLEAR: begin
                mark_we  = 1'b1;
                idx_next = idx_reg + 1'b1;
                if (idx_next == count_reg) begin
                    idx_next   = '0;
                    state_next = phc_pkg::ST_SEED_RD;
                end
            end
            phc_pkg::ST_SEED_RD: begin
                state_next = phc_pkg::ST_SEED_EV;
            end
            phc_pkg::ST_SEED_EV: begin
                if (mark_rd_reg) begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = phc_pkg::ST_SEED_RD;
                end else begin
                    mark_we       = 1'b1;
                    mark_wdata    = 1'b1;
                    list_we       = 1'b1;
                    list_waddr    = '0;
                    len_next      = CW'(1);
                    head_next     = '0;
                    asg_next      = asg_reg + 1'b1;
                    seed_row_next = hit_rd_reg.row;
                    seed_col_next = hit_rd_reg.col;
                    q_next        = SW'(hit_rd_reg.charge);
                    wr_next       = WRW'(prod_r);
                    wc_next       = WCW'(prod_c);
                    state_next    = phc_pkg::ST_HEAD_RD;
                end
            end
            phc_pkg::ST_HEAD_RD: begin
                if (head_reg == len_reg) begin
                    dcnt_next  = '0;
                    rmr_next   = '0;
                    rmc_next   = '0;
                    qor_next   = '0;
                    qoc_next   = '0;
                    dvr_next   = DW'(wr_reg) << FRAC_BITS;
                    dvc_next   = DW'(wc_reg) << FRAC_BITS;
                    state_next = phc_pkg::ST_DIV;
                end else begin
                    head_next  = head_reg + 1'b1;
                    state_next = phc_pkg::ST_CUR_RD;
                end
            end
            phc_pkg::ST_CUR_RD: begin
                hit_raddr  = list_rd_reg;
                state_next = phc_pkg::ST_CUR_EV;
            end
            phc_pkg::ST_CUR_EV: begin
                cur_row_next = hit_rd_reg.row;
                cur_col_next = hit_rd_reg.col;
                hit_raddr    = '0;
                mark_raddr   = '0;
                scan_next    = CW'(1);
                state_next   = phc_pkg::ST_SCAN;
            end
            phc_pkg::ST_SCAN: begin
                // judge the hit read last cycle, issue the next one
                mark_waddr = IW'(scan_reg - 1'b1);
                list_wdata = IW'(scan_reg - 1'b1);
                if (!mark_rd_reg && near) begin
                    mark_we    = 1'b1;
                    mark_wdata = 1'b1;
                    list_we    = 1'b1;
                    len_next   = len_reg + 1'b1;
                    asg_next   = asg_reg + 1'b1;
                    accumulate = 1'b1;
                end
                hit_raddr  = scan_reg[IW-1:0];
                mark_raddr = scan_reg[IW-1:0];
                if (scan_reg == count_reg) begin
                    state_next = phc_pkg::ST_HEAD_RD;
                end else begin
                    scan_next = scan_reg + 1'b1;
                end
            end
            phc_pkg::ST_DIV: begin
                dvr_next  = dvr_reg << 1;
                dvc_next  = dvc_reg << 1;
                rmr_next  = ger ? SW'(shr - {1'b0, q_reg}) : SW'(shr);
                rmc_next  = gec ? SW'(shc - {1'b0, q_reg}) : SW'(shc);
                qor_next  = {qor_reg[DW-2:0], ger};
                qoc_next  = {qoc_reg[DW-2:0], gec};
                dcnt_next = dcnt_reg + 1'b1;
                if (dcnt_reg == DCW'(DW) || q_reg == '0) begin
                    m_data_next.cluster_charge = (q_reg > SW'(phc_pkg::CHARGE_SAT))
                        ? phc_pkg::CHARGE_SAT : 18'(q_reg);
                    m_data_next.cluster_size = (len_reg > CW'(phc_pkg::SIZE_SAT))
                        ? phc_pkg::SIZE_SAT : 7'(len_reg);
                    m_data_next.centroid_row = (q_reg == '0) ? 12'd0 :
                        (qor_reg > DW'(phc_pkg::CROW_SAT)) ? phc_pkg::CROW_SAT
                                                          : 12'(qor_reg);
                    m_data_next.centroid_col = (q_reg == '0) ? 13'd0 :
                        (qoc_reg > DW'(phc_pkg::CCOL_SAT)) ? phc_pkg::CCOL_SAT
                                                          : 13'(qoc_reg);
                    m_data_next.seed_row     = seed_row_reg;
                    m_data_next.seed_col     = seed_col_reg;
                    m_data_next.zero_charge  = (q_reg == '0);
                    m_data_next.hits_dropped = ovf_reg;
                    m_data_next.last_cluster = (asg_reg == count_reg);
                    m_valid_next             = 1'b1;
                    state_next               = phc_pkg::ST_OUT;
                end
            end
            phc_pkg::ST_OUT: begin
                if (m_ready) begin
                    m_valid_next = 1'b0;
                    if (m_data_reg.last_cluster) begin
                        count_next = '0;
                        ovf_next   = 1'b0;
                        state_next = phc_pkg::ST_LOAD;
                    end else begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = phc_pkg::ST_SEED_RD;
                    end
                end
            end
            default: state_next = phc_pkg::ST_LOAD;
        endcase

        // add a joined member into the sums
        if (accumulate) begin
            q_next  = q_reg + SW'(hit_rd_reg.charge);
            wr_next = wr_reg + WRW'(prod_r);
            wc_next = wc_reg + WCW'(prod_c);
        end
    end

    // memory ports
    always_ff @(posedge aclk) begin
        if (hit_we) begin
            hit_mem[count_reg[IW-1:0]] <= hit_wdata;
        end
        hit_rd_reg <= hit_mem[hit_raddr];
    end

    always_ff @(posedge aclk) begin
        if (mark_we) begin
            mark_mem[mark_waddr] <= mark_wdata;
        end
        mark_rd_reg <= mark_mem[mark_raddr];
    end

    always_ff @(posedge aclk) begin
        if (list_we) begin
            list_mem[list_waddr] <= list_wdata;
        end
        list_rd_reg <= list_mem[head_reg[IW-1:0]];
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= phc_pkg::ST_LOAD;
            radius_reg  <= phc_pkg::RADIUS_RESET;
            count_reg   <= '0;
            ovf_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            ovf_reg     <= ovf_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                radius_reg <= cfg_wdata;
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        idx_reg      <= idx_next;
        scan_reg     <= scan_next;
        len_reg      <= len_next;
        head_reg     <= head_next;
        asg_reg      <= asg_next;
        cur_row_reg  <= cur_row_next;
        cur_col_reg  <= cur_col_next;
        seed_row_reg <= seed_row_next;
        seed_col_reg <= seed_col_next;
        q_reg        <= q_next;
        wr_reg       <= wr_next;
        wc_reg       <= wc_next;
        dcnt_reg     <= dcnt_next;
        dvr_reg      <= dvr_next;
        dvc_reg      <= dvc_next;
        rmr_reg      <= rmr_next;
        rmc_reg      <= rmc_next;
        qor_reg      <= qor_next;
        qoc_reg      <= qoc_next;
        m_data_reg   <= m_data_next;
    end

    a_out_in_out_state: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> state_reg == phc_pkg::ST_OUT)
        else $error("result word valid outside output state");

    a_no_load_while_out: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !m_valid_reg)
        else $error("input accepted while a cluster is pending");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(MAX_HITS))
        else $error("hit count beyond buffer depth");

    a_drop_leaves_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_data.hit_valid && count_reg == CW'(MAX_HITS)
         && !s_data.event_end) |=> ovf_reg)
        else $error("dropped hit not flagged");

endmodule
